FILE: sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned QuotInW  = 16;   // operand width of the divide-by-255 unit
  localparam int unsigned FracW    = 8;
  localparam int unsigned SectorW  = 3;

  // 255 * 256: denominator of the q and t levels
  localparam logic [15:0] TurnDen  = 16'd65280;
  // half of TurnDen, added before the shift by 8 for round half up
  localparam logic [23:0] TurnHalf = 24'd32640;
  // (2 * n + 255) / 2 reduces to n + 127
  localparam logic [15:0] PHalf    = 16'd127;
  localparam logic [7:0]  ChanMax  = 8'd255;

  // Hue sectors, sixths of a turn
  typedef enum logic [SectorW-1:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYA = 3'd2,
    SEC_CYA_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

endpackage

FILE: sv/hsv2rgb_div255.sv
module hsv2rgb_div255
  import hsv2rgb_pkg::*;
(
  input  logic [QuotInW-1:0] dividend_i,
  output logic [ChanW-1:0]   quotient_o
);

  logic [QuotInW-1:0] sum;

  // floor(x / 255) = (x + (x >> 8) + 1) >> 8 for x below 65280, which also
  // keeps the sum inside 16 bits
  always_comb begin
    sum = dividend_i + {{(QuotInW-ChanW){1'b0}}, dividend_i[QuotInW-1:ChanW]}
          + {{(QuotInW-1){1'b0}}, 1'b1};
    quotient_o = sum[QuotInW-1:ChanW];
  end

endmodule

FILE: sv/hsv_to_rgb_converter.sv
// HSV to RGB converter, 8 bits per channel, exact fixed point.
//
// Input channel: drive hue_i, saturation_i and brightness_i with start_i high.
// The word is taken at the rising edge where start_i is high and busy_o is low.
// busy_o is always low: a new word may enter in every cycle.
//
// Output channel: done_o is high for exactly one cycle together with red_o,
// green_o and blue_o. The receiver cannot stall, so nothing waits in the block.
//
// Throughput: one word per cycle, set by the five-stage pipeline:
//   1 hue * 6 into sector and fraction
//   2 saturation products s*f and s*(256-f), subtracted from 65280
//   3 brightness products v * level numerators
//   4 round half up and scale by 1/256
//   5 divide by 255, sector permutation, output register
// Reset clears the valid bits of all stages; data registers keep garbage,
// and done_o stays low until a word has run through.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [ChanW-1:0] hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] brightness_i,
  output logic             done_o,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  // Pipeline never holds off the sender
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // ---------------- stage 1: sector and fraction ----------------
  logic [10:0]        h6_d;
  logic               vld1_q;
  sector_e            sec1_q;
  logic [FracW-1:0]   frac1_q;
  logic [ChanW-1:0]   sat1_q, val1_q;

  // hue * 6 = hue * 4 + hue * 2
  assign h6_d = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sec1_q  <= sector_e'(h6_d[10:8]);
    frac1_q <= h6_d[7:0];
    sat1_q  <= saturation_i;
    val1_q  <= brightness_i;
  end

  // ---------------- stage 2: saturation terms ----------------
  logic [15:0]      sf_d;
  logic [16:0]      sfc_d;
  logic [8:0]       fcomp_d;
  logic [15:0]      aq_d, at_d;
  logic             vld2_q, grey2_q;
  sector_e          sec2_q;
  logic [ChanW-1:0] val2_q, ap2_q;
  logic [15:0]      aq2_q, at2_q;

  always_comb begin
    fcomp_d = 9'd256 - {1'b0, frac1_q};
    sf_d    = sat1_q * frac1_q;
    sfc_d   = {9'd0, sat1_q} * {8'd0, fcomp_d};
    // both products stay at or below 65280, so the levels fit 16 bits
    aq_d    = TurnDen - sf_d;
    at_d    = 16'(17'(TurnDen) - sfc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec2_q  <= sec1_q;
    grey2_q <= (sat1_q == '0);
    val2_q  <= val1_q;
    ap2_q   <= ChanMax - sat1_q;
    aq2_q   <= aq_d;
    at2_q   <= at_d;
  end

  // ---------------- stage 3: brightness products ----------------
  logic             vld3_q, grey3_q;
  sector_e          sec3_q;
  logic [ChanW-1:0] val3_q;
  logic [15:0]      np3_q;
  logic [23:0]      nq3_q, nt3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec3_q  <= sec2_q;
    grey3_q <= grey2_q;
    val3_q  <= val2_q;
    np3_q   <= val2_q * ap2_q;
    nq3_q   <= {16'd0, val2_q} * {8'd0, aq2_q};
    nt3_q   <= {16'd0, val2_q} * {8'd0, at2_q};
  end

  // ---------------- stage 4: round half up, drop 1/256 ----------------
  logic [23:0]        rq_d, rt_d;
  logic               vld4_q, grey4_q;
  sector_e            sec4_q;
  logic [ChanW-1:0]   val4_q;
  logic [QuotInW-1:0] yp4_q, yq4_q, yt4_q;

  assign rq_d = nq3_q + TurnHalf;
  assign rt_d = nt3_q + TurnHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec4_q  <= sec3_q;
    grey4_q <= grey3_q;
    val4_q  <= val3_q;
    yp4_q   <= np3_q + PHalf;
    yq4_q   <= rq_d[23:8];
    yt4_q   <= rt_d[23:8];
  end

  // ---------------- stage 5: divide by 255 and permute ----------------
  logic [ChanW-1:0] lvl_p, lvl_q, lvl_t;
  logic [ChanW-1:0] red_d, green_d, blue_d;
  logic             vld5_q;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  hsv2rgb_div255 u_div_p (.dividend_i(yp4_q), .quotient_o(lvl_p));
  hsv2rgb_div255 u_div_q (.dividend_i(yq4_q), .quotient_o(lvl_q));
  hsv2rgb_div255 u_div_t (.dividend_i(yt4_q), .quotient_o(lvl_t));

  always_comb begin
    red_d   = val4_q;
    green_d = val4_q;
    blue_d  = val4_q;
    if (!grey4_q) begin
      unique case (sec4_q)
        SEC_RED_YEL: begin red_d = val4_q; green_d = lvl_t;  blue_d = lvl_p;  end
        SEC_YEL_GRN: begin red_d = lvl_q;  green_d = val4_q; blue_d = lvl_p;  end
        SEC_GRN_CYA: begin red_d = lvl_p;  green_d = val4_q; blue_d = lvl_t;  end
        SEC_CYA_BLU: begin red_d = lvl_p;  green_d = lvl_q;  blue_d = val4_q; end
        SEC_BLU_MAG: begin red_d = lvl_t;  green_d = lvl_p;  blue_d = val4_q; end
        default:     begin red_d = val4_q; green_d = lvl_p;  blue_d = lvl_q;  end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else begin
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = vld5_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

FILE: dv/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  // Idle cycles in which no word is accepted or returned before the run is declared hung.
  // The sender gaps stay well below this limit, and the pipeline is 5 deep.
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomWords = 1800;
  // Cycles to idle after the last result has been checked
  localparam int unsigned TailCycles  = 12;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // One HSV word as it waits in the sender queue
  typedef struct {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] bri;
    int unsigned      gap_after;  // idle cycles after this word is taken
    bit               drain;      // hold off until no RGB word is outstanding
  } hsv_word_t;

  // Predicted RGB word, carrying its HSV source for the log
  typedef struct {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] bri;
    rgb_t             rgb;
  } rgb_expect_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [ChanW-1:0] hue_i        = '0;
  logic [ChanW-1:0] saturation_i = '0;
  logic [ChanW-1:0] brightness_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  hsv_word_t   hsv_words_q[$];
  rgb_expect_t rgb_pending_q[$];

  logic        word_taken   = 1'b0;
  int unsigned idle_left    = 0;
  int unsigned burst_left   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned rgb_seen_cnt = 0;
  int unsigned grey_cnt     = 0;
  int unsigned drain_cnt    = 0;
  int unsigned stall_cycles = 0;
  int unsigned sector_hits[6];

  hsv_to_rgb_converter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .done_o       (done_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict one RGB word. Hue * 6 splits into the sector (top bits) and the
  // fraction of the sector (low 8 bits). The three levels p, q and t are exact
  // rationals rounded half up, computed as (2 * num + den) / (2 * den).
  function automatic rgb_t rgb_of_hsv(logic [ChanW-1:0] hue, logic [ChanW-1:0] sat,
                                      logic [ChanW-1:0] bri);
    logic [10:0] h6;
    sector_e     sec;
    int unsigned s, v, frac, p, q, t;
    rgb_t        c;
    s = sat;
    v = bri;
    if (s == 0) begin
      // Zero saturation: plain grey at the brightness level
      c = '{red: bri, green: bri, blue: bri};
    end else begin
      h6   = hue * 11'd6;
      sec  = sector_e'(h6[10:8]);
      frac = h6[7:0];
      p = (2 * v * (ChanMax - s) + ChanMax) / (2 * ChanMax);
      q = (2 * v * (TurnDen - s * frac) + TurnDen) / (2 * TurnDen);
      t = (2 * v * (TurnDen - s * (256 - frac)) + TurnDen) / (2 * TurnDen);
      case (sec)
        SEC_RED_YEL: c = '{red: 8'(v), green: 8'(t), blue: 8'(p)};
        SEC_YEL_GRN: c = '{red: 8'(q), green: 8'(v), blue: 8'(p)};
        SEC_GRN_CYA: c = '{red: 8'(p), green: 8'(v), blue: 8'(t)};
        SEC_CYA_BLU: c = '{red: 8'(p), green: 8'(q), blue: 8'(v)};
        SEC_BLU_MAG: c = '{red: 8'(t), green: 8'(p), blue: 8'(v)};
        default:     c = '{red: 8'(v), green: 8'(p), blue: 8'(q)};
      endcase
    end
    return c;
  endfunction

  // Print one mismatch line and count it; the run goes on to its normal end.
  task automatic report_mismatch(string what, rgb_expect_t e, logic [ChanW-1:0] got,
                                 logic [ChanW-1:0] want);
    mismatch_cnt++;
    $display("%0t: MISMATCH %s for h=%0d s=%0d v=%0d: got %0d, expected %0d",
             $time, what, e.hue, e.sat, e.bri, got, want);
  endtask

  // Queue one HSV word. Gaps are mostly zero or short, a few long, and now
  // and then a burst of back-to-back words with no idling at all.
  task automatic add_word(logic [ChanW-1:0] hue, logic [ChanW-1:0] sat,
                          logic [ChanW-1:0] bri, bit drain);
    hsv_word_t   w;
    int unsigned r;
    w.hue   = hue;
    w.sat   = sat;
    w.bri   = bri;
    w.drain = drain;
    if (burst_left > 0) begin
      w.gap_after = 0;
      burst_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 60) w.gap_after = 0;
      else if (r < 88) w.gap_after = $urandom_range(1, 4);
      else if (r < 97) w.gap_after = $urandom_range(5, 15);
      else w.gap_after = $urandom_range(30, 60);
      if ($urandom_range(49) == 0) burst_left = $urandom_range(20, 80);
    end
    if (drain) drain_cnt++;
    hsv_words_q.push_back(w);
  endtask

  // Driver: change inputs on the falling edge only. Hold the current word
  // until it is taken, then idle for its gap, then present the next one.
  always @(negedge clk_i) begin
    hsv_word_t w;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !word_taken) begin
      // hold: word not yet taken
    end else if (idle_left > 0) begin
      start_i <= 1'b0;
      idle_left--;
    end else if (hsv_words_q.size() == 0 ||
                 (hsv_words_q[0].drain && rgb_pending_q.size() != 0)) begin
      // stop: nothing left, or wait for every outstanding RGB word first
      start_i <= 1'b0;
    end else begin
      w = hsv_words_q.pop_front();
      hue_i        <= w.hue;
      saturation_i <= w.sat;
      brightness_i <= w.bri;
      start_i      <= 1'b1;
      idle_left    = w.gap_after;
    end
  end

  // Monitor: sample on the rising edge. Check a result against the oldest
  // prediction first, then record the word taken at this same edge.
  always @(posedge clk_i) begin
    rgb_expect_t e;
    if (rst_ni && done_o !== 1'b0) begin
      if (rgb_pending_q.size() == 0) begin
        e = '{hue: 'x, sat: 'x, bri: 'x, rgb: 'x};
        report_mismatch("unexpected RGB word, red", e, red_o, 'x);
      end else begin
        e = rgb_pending_q.pop_front();
        rgb_seen_cnt++;
        if (done_o !== 1'b1)
          report_mismatch("done strobe unknown, red", e, red_o, e.rgb.red);
        if (red_o !== e.rgb.red)     report_mismatch("red",   e, red_o,   e.rgb.red);
        if (green_o !== e.rgb.green) report_mismatch("green", e, green_o, e.rgb.green);
        if (blue_o !== e.rgb.blue)   report_mismatch("blue",  e, blue_o,  e.rgb.blue);
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      e.hue = hue_i;
      e.sat = saturation_i;
      e.bri = brightness_i;
      e.rgb = rgb_of_hsv(hue_i, saturation_i, brightness_i);
      rgb_pending_q.push_back(e);
      if (saturation_i == 0) grey_cnt++;
      else sector_hits[(hue_i * 11'd6) >> 8]++;
      word_taken <= 1'b1;
    end else begin
      word_taken <= 1'b0;
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [ChanW-1:0] h, s, v;
    int unsigned      mode;

    // Directed words: grey, all-zero and all-full corners, both sides of
    // every sector boundary, and a rounding tie exactly on one half.
    add_word(8'd0,   8'd0,   8'd0,   1'b0);
    add_word(8'd0,   8'd0,   8'd255, 1'b0);
    add_word(8'd123, 8'd0,   8'd77,  1'b0);
    add_word(8'd255, 8'd255, 8'd0,   1'b0);
    add_word(8'd255, 8'd255, 8'd255, 1'b0);
    foreach (sector_hits[k]) begin
      // first and last hue of each sixth of a turn, full color
      add_word(8'((k * 256 + 5) / 6), 8'd255, 8'd255, 1'b0);
      add_word(8'(((k + 1) * 256 + 5) / 6 - 1), 8'd255, 8'd255, 1'b0);
    end
    add_word(8'd1,   8'd1,   8'd1,   1'b0);
    add_word(8'd200, 8'd1,   8'd255, 1'b0);
    add_word(8'd43,  8'd255, 8'd64,  1'b0);  // q lands exactly on a half
    add_word(8'd85,  8'd128, 8'd200, 1'b0);
    add_word(8'd170, 8'd170, 8'd85,  1'b0);
    add_word(8'd85,  8'd85,  8'd170, 1'b0);

    // Random words: mostly uniform, some pinned to saturation or brightness
    // extremes. Drain the pipeline before a few of them.
    for (int i = 0; i < RandomWords; i++) begin
      h    = $urandom_range(255);
      s    = $urandom_range(255);
      v    = $urandom_range(255);
      mode = $urandom_range(99);
      if (mode < 12) begin
        case ($urandom_range(3))
          0: s = 8'd0;
          1: s = 8'd1;
          2: s = 8'd254;
          default: s = 8'd255;
        endcase
      end else if (mode < 22) begin
        v = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
      end
      add_word(h, s, v, (i % 300) == 0);
    end

    // Reset once, released on a falling edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for the sender to empty and every RGB word to come back
    while (hsv_words_q.size() != 0 || start_i || rgb_pending_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d RGB words, %0d of them grey, %0d drain pauses",
             rgb_seen_cnt, grey_cnt, drain_cnt);
    $display("Hue sector hits: %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
             sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
    if (mismatch_cnt == 0 && rgb_pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d RGB words missing", mismatch_cnt, rgb_pending_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: hsv_to_rgb_converter.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_div255.sv
sv/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_tb.sv
